// ===== rtl/saturating_count_min_sketch_macros.svh =====
// assertion helpers for the sketch rtl
`ifndef SATURATING_COUNT_MIN_SKETCH_MACROS_SVH
`define SATURATING_COUNT_MIN_SKETCH_MACROS_SVH

// checked only outside reset
`define SCMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define SCMS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/scms_pkg.sv =====
`default_nettype none

package scms_pkg;

  localparam int ROWS    = 3;
  localparam int CNT_W   = 32;
  localparam int ADD_W   = 31;
  localparam int KEY_W   = 16;
  localparam int MOD_W   = 17;
  localparam int STEP_W  = $clog2(KEY_W);
  localparam int CBITS_W = 6;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] REG_COUNTER_BITS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ROW_SIZE     = 2'd1;

  localparam logic [CNT_W-1:0] CEIL_RESET = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_READ,
    OP_ADD,
    OP_SUB,
    OP_SET
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic rd;
    logic wb;
    logic clr;
    op_e  op;
  } lane_ctl_t;

  // saturation ceiling 2^(bits-1)-1, bits clamped to 1..32
  function automatic logic [CNT_W-1:0] ceiling_of(logic [CBITS_W-1:0] bits);
    logic [4:0] sh;
    if (bits == '0) begin
      sh = 5'd0;
    end else if (bits > 6'd32) begin
      sh = 5'd31;
    end else begin
      sh = 5'(bits - 6'd1);
    end
    return (32'd1 << sh) - 32'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/saturating_count_min_sketch.sv =====
// Three-row count-min sketch of saturating counters, ROW_ENTRIES 32-bit counters
// per row. After reset a clearing pass zeroes all rows, one entry of each row per
// cycle; requests wait during it, configuration writes are taken. Each request
// goes from transfer to result through the transfer, the steps in which each row's
// remainder unit reduces its 16-bit hash half modulo the row size one bit per
// cycle, one memory read and one write-back. One request is in flight at a time;
// the finished result sits in an output register, so the next request can be
// taken while it waits. Counter width and row size must be written only while no
// request is outstanding; the block itself does not enforce this.
`default_nettype none

module saturating_count_min_sketch
  import scms_pkg::*;
#(
  parameter int ROW_ENTRIES = 65536
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [31:0]       hash_a_i,
  input  wire logic [31:0]       hash_b_i,
  input  wire logic [ADD_W-1:0]  add_row0_i,
  input  wire logic [ADD_W-1:0]  add_row1_i,
  input  wire logic [ADD_W-1:0]  add_row2_i,
  input  wire logic [CNT_W-1:0]  amount_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [CNT_W-1:0]  count_row0_o,
  output logic      [CNT_W-1:0]  count_row1_o,
  output logic      [CNT_W-1:0]  count_row2_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CIDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);

  `include "saturating_count_min_sketch_macros.svh"

  localparam int IDX_W = (ROW_ENTRIES > 1) ? $clog2(ROW_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ROW_ENTRIES - 1);
  localparam logic [MOD_W-1:0] MOD_MAX  = MOD_W'(ROW_ENTRIES);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(KEY_W - 1);

  state_e state_q, state_d;
  logic [IDX_W-1:0]  clr_cnt_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  ceil_q;
  logic [MOD_W-1:0]  mod_q;
  logic [MOD_W-1:0]  row_size;
  op_e               op_q;
  logic [CNT_W-1:0]  amount_q;
  logic [ADD_W-1:0]  add_q [ROWS];
  logic [KEY_W-1:0]  key [ROWS];
  logic [CNT_W-1:0]  count [ROWS];
  logic [CNT_W-1:0]  count_q [ROWS];
  logic              out_valid_q;
  logic              in_fire;
  logic              slot_free;
  logic              wr_fire;
  lane_ctl_t         ctl;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign wr_fire   = (state_q == ST_WRITE) && slot_free;

  assign key[0] = hash_a_i[KEY_W-1:0];
  assign key[1] = hash_a_i[2*KEY_W-1:KEY_W];
  assign key[2] = hash_b_i[KEY_W-1:0];

  // configuration
  assign cfg_ready_o = 1'b1;
  assign row_size    = cfg_data_i[MOD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= CEIL_RESET;
      mod_q  <= MOD_MAX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COUNTER_BITS: ceil_q <= ceiling_of(cfg_data_i[CBITS_W-1:0]);
        REG_ROW_SIZE: begin
          mod_q <= (row_size == '0 || row_size > MOD_MAX) ? MOD_MAX : row_size;
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_MOD;
      ST_MOD:   if (step_q == STEP_LAST) state_d = ST_READ;
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    ctl.load   = in_fire;
    ctl.step   = (state_q == ST_MOD);
    ctl.rd     = (state_q == ST_READ);
    ctl.wb     = wr_fire;
    ctl.clr    = (state_q == ST_CLEAR);
    ctl.op     = op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      step_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (in_fire) begin
        step_q <= '0;
      end else if (state_q == ST_MOD) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_e'(opcode_i);
      amount_q <= amount_i;
      add_q[0] <= add_row0_i;
      add_q[1] <= add_row1_i;
      add_q[2] <= add_row2_i;
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    scms_lane #(
      .ROW_ENTRIES (ROW_ENTRIES),
      .IDX_W       (IDX_W)
    ) u_lane (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .key_i      (key[r]),
      .modulus_i  (mod_q),
      .clr_addr_i (clr_cnt_q),
      .ceil_i     (ceil_q),
      .add_i      (add_q[r]),
      .amount_i   (amount_q),
      .count_o    (count[r])
    );
  end

  // merge the three lane results into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      count_q[0] <= count[0];
      count_q[1] <= count[1];
      count_q[2] <= count[2];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign count_row0_o = count_q[0];
  assign count_row1_o = count_q[1];
  assign count_row2_o = count_q[2];

  `SCMS_ASSERT(a_accept_starts_mod, in_fire |=> state_q == ST_MOD,
               "transfer did not start the remainder steps")
  `SCMS_ASSERT(a_result_from_write, $rose(out_valid_q) |-> $past(state_q) == ST_WRITE,
               "result appeared outside write-back")
  `SCMS_ASSERT(a_add_saturates,
               (wr_fire && op_q == OP_ADD) |=> (count_q[0] <= $past(ceil_q)
               && count_q[1] <= $past(ceil_q) && count_q[2] <= $past(ceil_q)),
               "add result above ceiling")
  `SCMS_ASSERT(a_clear_complete,
               (state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |->
               $past(clr_cnt_q) == CLR_LAST,
               "clearing pass ended early")
  `SCMS_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o,
                      "request taken during clearing pass")

endmodule

`default_nettype wire

// ===== rtl/scms_mod.sv =====
`default_nettype none

// restoring remainder, one dividend bit per step
module scms_mod
  import scms_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [MOD_W-1:0] modulus_i,
  output logic      [MOD_W-1:0] rem_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [MOD_W-1:0] rem_q, rem_d;
  logic [MOD_W:0]   trial;
  logic [MOD_W:0]   diff;

  always_comb begin
    trial = {rem_q, key_q[KEY_W-1]};
    diff  = trial - {1'b0, modulus_i};
    key_d = key_q;
    rem_d = rem_q;
    if (load_i) begin
      key_d = key_i;
      rem_d = '0;
    end else if (step_i) begin
      key_d = {key_q[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, modulus_i}) begin
        rem_d = diff[MOD_W-1:0];
      end else begin
        rem_d = trial[MOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/scms_lane.sv =====
`default_nettype none

// one sketch row: index remainder, counter memory and update
module scms_lane
  import scms_pkg::*;
#(
  parameter int ROW_ENTRIES = 65536,
  parameter int IDX_W       = 16
) (
  input  wire logic             clk_i,
  input  wire lane_ctl_t        ctl_i,
  input  wire logic [KEY_W-1:0] key_i,
  input  wire logic [MOD_W-1:0] modulus_i,
  input  wire logic [IDX_W-1:0] clr_addr_i,
  input  wire logic [CNT_W-1:0] ceil_i,
  input  wire logic [ADD_W-1:0] add_i,
  input  wire logic [CNT_W-1:0] amount_i,
  output logic      [CNT_W-1:0] count_o
);

  logic [CNT_W-1:0] mem [ROW_ENTRIES];
  logic [CNT_W-1:0] rdata_q;
  logic [MOD_W-1:0] rem;
  logic [IDX_W-1:0] idx;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] upd;

  scms_mod u_mod (
    .clk_i     (clk_i),
    .load_i    (ctl_i.load),
    .step_i    (ctl_i.step),
    .key_i     (key_i),
    .modulus_i (modulus_i),
    .rem_o     (rem)
  );

  // remainder is below the modulus, which never exceeds the row depth
  assign idx = rem[IDX_W-1:0];

  always_comb begin
    sum = {1'b0, rdata_q} + {{(CNT_W+1-ADD_W){1'b0}}, add_i};
    case (ctl_i.op)
      OP_READ: upd = rdata_q;
      OP_ADD:  upd = (sum > {1'b0, ceil_i}) ? ceil_i : sum[CNT_W-1:0];
      OP_SUB:  upd = (rdata_q < amount_i) ? '0 : rdata_q - amount_i;
      OP_SET:  upd = amount_i;
      default: upd = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      mem[clr_addr_i] <= '0;
    end else if (ctl_i.wb) begin
      mem[idx] <= upd;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[idx];
    end
  end

  assign count_o = upd;

endmodule

`default_nettype wire
